[design/mrmf_pkg.sv]
// ============================================================================
// MIDI redundant message filter package
// Shared widths, message type codes and the controller/datapath link types.
// ============================================================================
`default_nettype none

package mrmf_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int SENT_W      = 32;
    localparam int CNT_EXT_W   = (COUNT_WIDTH > SENT_W) ? COUNT_WIDTH : SENT_W;

    localparam int CC_DEPTH    = 2048;
    localparam int CC_ADDR_W   = $clog2(CC_DEPTH);
    localparam int PROG_DEPTH  = 16;
    localparam int CHAN_W      = $clog2(PROG_DEPTH);
    localparam int DATA_W      = 7;
    localparam int ENTRY_W     = 8;

    localparam logic [3:0]         TYPE_CC      = 4'hB;
    localparam logic [3:0]         TYPE_PROGRAM = 4'hC;
    localparam logic [ENTRY_W-1:0] EMPTY_ENTRY  = 8'hFF;

    typedef struct packed {
        logic clear_en;
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

[design/mrmf_in_if.sv]
// ============================================================================
// MIDI message input channel
// Valid/ready channel carrying one three-byte short message per beat.
// ============================================================================
`default_nettype none

interface mrmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd;
    logic [7:0] first_data;
    logic [7:0] second_data;

    modport source (output valid, output cmd, output first_data, output second_data,
                    input ready);
    modport sink   (input valid, input cmd, input first_data, input second_data,
                    output ready);
endinterface

`default_nettype wire

[design/mrmf_out_if.sv]
// ============================================================================
// MIDI filter result channel
// Valid/ready channel carrying one filter decision per beat.
// ============================================================================
`default_nettype none

interface mrmf_out_if;
    logic        valid;
    logic        ready;
    logic        forward;
    logic [7:0]  status_out;
    logic [6:0]  data1_out;
    logic [6:0]  data2_out;
    logic [31:0] sent_total;

    modport source (output valid, output forward, output status_out, output data1_out,
                    output data2_out, output sent_total, input ready);
    modport sink   (input valid, input forward, input status_out, input data1_out,
                    input data2_out, input sent_total, output ready);
endinterface

`default_nettype wire

[design/mrmf_ctrl.sv]
// ============================================================================
// MIDI filter controller
// Sequences the post-reset store clear, message capture and decision commit.
// ============================================================================
`default_nettype none

module mrmf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mrmf_pkg::dp_stat_t  stat,
    output mrmf_pkg::ctrl_cmd_t      cmd
);
    import mrmf_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.clear_en = 1'b0;
        cmd.capture  = 1'b0;
        cmd.commit   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !stat.out_busy)
        else $error("commit while result register is occupied");

    a_capture_then_decide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_DECIDE))
        else $error("captured message not followed by a decision");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> !in_ready)
        else $error("input accepted during store clear");
`endif

endmodule

`default_nettype wire

[design/mrmf_datapath.sv]
// ============================================================================
// MIDI filter datapath
// Holds the controller and program stores, the sent counter and the result
// register, and makes the suppress or forward decision.
// ============================================================================
`default_nettype none

module mrmf_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mrmf_pkg::ctrl_cmd_t cmd,
    output mrmf_pkg::dp_stat_t       stat,
    input  wire logic [7:0]          in_cmd,
    input  wire logic [7:0]          in_first_data,
    input  wire logic [7:0]          in_second_data,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic                     out_forward,
    output logic [7:0]               out_status,
    output logic [6:0]               out_data1,
    output logic [6:0]               out_data2,
    output logic [31:0]              out_sent_total
);
    import mrmf_pkg::*;

    logic [ENTRY_W-1:0]     cc_mem [CC_DEPTH];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic [ENTRY_W-1:0]     prog_reg [PROG_DEPTH];
    logic [CC_ADDR_W-1:0]   clr_addr_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [CNT_EXT_W-1:0]   count_ext;
    logic                   out_valid_reg;
    logic                   out_forward_reg;
    logic [7:0]             out_status_reg;
    logic [DATA_W-1:0]      out_data1_reg;
    logic [DATA_W-1:0]      out_data2_reg;
    logic [SENT_W-1:0]      out_sent_reg;

    logic [7:0]             status_reg;
    logic [DATA_W-1:0]      d1_reg;
    logic [DATA_W-1:0]      d2_reg;

    logic [CC_ADDR_W-1:0]   rd_addr;
    logic [CC_ADDR_W-1:0]   cc_addr;
    logic [CHAN_W-1:0]      chan;
    logic                   is_cc;
    logic                   is_pc;
    logic                   send;
    logic                   wr_en;
    logic [CC_ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]     wr_data;

    assign rd_addr = {in_cmd[CHAN_W-1:0], in_first_data[DATA_W-1:0]};
    assign chan    = status_reg[CHAN_W-1:0];
    assign cc_addr = {chan, d1_reg};
    assign is_cc   = (status_reg[7:4] == TYPE_CC);
    assign is_pc   = (status_reg[7:4] == TYPE_PROGRAM);

    always_comb
    begin
        send = 1'b1;
        if (is_cc && (rd_data_reg == {1'b0, d2_reg}))
        begin
            send = 1'b0;
        end
        if (is_pc && (prog_reg[chan] == {1'b0, d1_reg}))
        begin
            send = 1'b0;
        end
    end

    assign count_next = send ? (count_reg + COUNT_WIDTH'(1)) : count_reg;
    assign count_ext  = CNT_EXT_W'(count_next);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cc_addr;
        wr_data = {1'b0, d2_reg};
        priority if (cmd.clear_en)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = EMPTY_ENTRY;
        end
        else if (cmd.commit && is_cc && send)
        begin
            wr_en = 1'b1;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cc_mem[wr_addr] <= wr_data;
        end
        if (cmd.capture)
        begin
            rd_data_reg <= cc_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            status_reg <= in_cmd;
            d1_reg     <= in_first_data[DATA_W-1:0];
            d2_reg     <= in_second_data[DATA_W-1:0];
        end
        if (cmd.commit)
        begin
            out_forward_reg <= send;
            out_status_reg  <= status_reg;
            out_data1_reg   <= d1_reg;
            out_data2_reg   <= d2_reg;
            out_sent_reg    <= count_ext[SENT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PROG_DEPTH; i++)
            begin
                prog_reg[i] <= EMPTY_ENTRY;
            end
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + CC_ADDR_W'(1);
            end
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                if (is_pc && send)
                begin
                    prog_reg[chan] <= {1'b0, d1_reg};
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_last = (clr_addr_reg == {CC_ADDR_W{1'b1}});
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid      = out_valid_reg;
    assign out_forward    = out_forward_reg;
    assign out_status     = out_status_reg;
    assign out_data1      = out_data1_reg;
    assign out_data2      = out_data2_reg;
    assign out_sent_total = out_sent_reg;

`ifndef ASSERT_OFF
    a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed decision did not load the result register");

    a_suppress_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !send) |=> (count_reg == $past(count_reg)))
        else $error("suppressed message changed the sent count");

    a_clear_walks_memory: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |=> (clr_addr_reg == $past(clr_addr_reg) + CC_ADDR_W'(1)))
        else $error("store clear address did not advance");
`endif

endmodule

`default_nettype wire

[design/midi_redundant_message_filter.sv]
// ============================================================================
// MIDI redundant message filter
// Clears the forward flag of control-change and program-change messages that
// repeat the stored value for their channel, and counts every message sent on.
// ============================================================================
// Usage:
// msg_in takes one short message per beat (status byte and two data bytes).
// msg_out returns exactly one result per message: the forward flag, the
// status byte, both data bytes masked to 7 bits and the running sent count.
// Each accepted message is registered, and its result is loaded on the
// decision, which waits while a pending result is stalled. The controller
// store is single port: read on acceptance, written back on the decision.
// After reset the block clears the 2048-entry controller store, one entry
// per cycle, and holds msg_in ready low until the clear is done.
// The result sits in an output register. While the receiver stalls, the
// block still accepts the next message and holds it until the register
// frees. Reset drops any pending result and zeroes the sent count.
// ============================================================================
`default_nettype none

module midi_redundant_message_filter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mrmf_in_if.sink    msg_in,
    mrmf_out_if.source msg_out
);
    import mrmf_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      in_ready;

    mrmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg_in.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mrmf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_cmd         (msg_in.cmd),
        .in_first_data  (msg_in.first_data),
        .in_second_data (msg_in.second_data),
        .out_ready      (msg_out.ready),
        .out_valid      (msg_out.valid),
        .out_forward    (msg_out.forward),
        .out_status     (msg_out.status_out),
        .out_data1      (msg_out.data1_out),
        .out_data2      (msg_out.data2_out),
        .out_sent_total (msg_out.sent_total)
    );

    assign msg_in.ready = in_ready;

endmodule

`default_nettype wire

[test/testbench.sv]
// ============================================================================
// MIDI redundant message filter testbench
// Sends a directed run of messages and then random traffic that repeats
// channels, controllers and values often. Each accepted message is run
// through a behavioral model of the filter's stores and counter. Each result
// beat is checked, field by field, against the oldest predicted result. The
// sender idles in bursts and the receiver stalls on its own pattern, with one
// long hold-off.
// ============================================================================
`default_nettype none

module testbench;

    import mrmf_pkg::*;

    localparam logic [3:0] TYPE_NOTE_OFF  = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON   = 4'h9;
    localparam logic [3:0] TYPE_POLY_AT   = 4'hA;
    localparam logic [3:0] TYPE_CHAN_AT   = 4'hD;
    localparam logic [3:0] TYPE_BEND      = 4'hE;
    localparam logic [3:0] TYPE_SYSTEM    = 4'hF;
    localparam logic [3:0] LAST_CHAN      = 4'hF;
    localparam int         RANDOM_MSGS    = 800;
    localparam int         HOLD_AFTER     = 250;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         MAX_PRINTS     = 100;

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] first_data;
        logic [7:0] second_data;
    } midi_msg_t;

    typedef struct packed {
        logic              forward;
        logic [7:0]        status;
        logic [DATA_W-1:0] data1;
        logic [DATA_W-1:0] data2;
        logic [SENT_W-1:0] total;
    } filter_result_t;

    logic clk;
    logic rst_n;

    mrmf_in_if  msg_in_ch ();
    mrmf_out_if msg_out_ch ();

    midi_redundant_message_filter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg_in  (msg_in_ch),
        .msg_out (msg_out_ch)
    );

    midi_msg_t        msg_pending[$];
    filter_result_t   filter_results[$];
    logic [ENTRY_W-1:0]     cc_last [CC_DEPTH];
    logic [ENTRY_W-1:0]     program_last [PROG_DEPTH];
    logic [COUNT_WIDTH-1:0] sent_count;

    int mismatches;
    int in_beats;
    int gap_left;
    int burst_left;
    int hold_left;
    bit hold_done;
    int rx_cycle;
    int rx_mode;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic filter_result_t filter_message(midi_msg_t m);
        filter_result_t    r;
        logic [DATA_W-1:0] d1;
        logic [DATA_W-1:0] d2;
        logic [3:0]        chan;
        logic              send;
        d1   = m.first_data[DATA_W-1:0];
        d2   = m.second_data[DATA_W-1:0];
        chan = m.cmd[3:0];
        send = 1'b1;
        if (m.cmd[7:4] == TYPE_CC)
        begin
            if (cc_last[{chan, d1}] == ENTRY_W'(d2))
                send = 1'b0;
            else
                cc_last[{chan, d1}] = ENTRY_W'(d2);
        end
        else if (m.cmd[7:4] == TYPE_PROGRAM)
        begin
            if (program_last[chan] == ENTRY_W'(d1))
                send = 1'b0;
            else
                program_last[chan] = ENTRY_W'(d1);
        end
        if (send)
            sent_count = sent_count + COUNT_WIDTH'(1);
        r.forward = send;
        r.status  = m.cmd;
        r.data1   = d1;
        r.data2   = d2;
        r.total   = SENT_W'(sent_count);
        return r;
    endfunction

    function automatic midi_msg_t random_message();
        midi_msg_t   m;
        int          pick;
        logic [3:0]  chan;
        logic [6:0]  num;
        logic [6:0]  val;
        pick = $urandom_range(0, 99);
        chan = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 2));
        case ($urandom_range(0, 4))
            0: num = 7'd0;
            1: num = 7'd7;
            2: num = 7'h7F;
            default: num = 7'($urandom_range(0, 127));
        endcase
        case ($urandom_range(0, 4))
            0: val = 7'd0;
            1: val = 7'd64;
            2: val = 7'h7F;
            3: val = 7'($urandom_range(0, 3));
            default: val = 7'($urandom_range(0, 127));
        endcase
        if ($urandom_range(0, 2) != 0)
            num = num & 7'h03;
        m.first_data  = {1'($urandom_range(0, 1)), num};
        m.second_data = {1'($urandom_range(0, 1)), val};
        if (pick < 45)
            m.cmd = {TYPE_CC, chan};
        else if (pick < 70)
            m.cmd = {TYPE_PROGRAM, chan};
        else
        begin
            m.cmd         = 8'($urandom_range(0, 255));
            m.first_data  = 8'($urandom_range(0, 255));
            m.second_data = 8'($urandom_range(0, 255));
        end
        return m;
    endfunction

    task automatic add_message(input logic [7:0] cmd, input logic [7:0] d1,
                               input logic [7:0] d2);
        midi_msg_t m;
        m.cmd         = cmd;
        m.first_data  = d1;
        m.second_data = d2;
        msg_pending.push_back(m);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            msg_in_ch.valid <= 1'b0;
        end
        else
        begin
            if (msg_in_ch.valid && msg_in_ch.ready)
            begin
                filter_results.push_back(filter_message(msg_pending.pop_front()));
                in_beats <= in_beats + 1;
            end
            if (!(msg_in_ch.valid && !msg_in_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    msg_in_ch.valid <= 1'b0;
                end
                else if (msg_pending.size() > 0)
                begin
                    msg_in_ch.valid       <= 1'b1;
                    msg_in_ch.cmd         <= msg_pending[0].cmd;
                    msg_in_ch.first_data  <= msg_pending[0].first_data;
                    msg_in_ch.second_data <= msg_pending[0].second_data;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 7);
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
                else
                begin
                    msg_in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!hold_done && in_beats >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            msg_out_ch.ready <= 1'b0;
        end
        else
        begin
            if (msg_out_ch.valid && msg_out_ch.ready)
            begin
                if (filter_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'(msg_out_ch.status_out), 32'd0);
                end
                else
                begin
                    filter_result_t want;
                    want = filter_results.pop_front();
                    if (msg_out_ch.forward !== want.forward)
                        report_mismatch("forward", 32'(msg_out_ch.forward),
                                        32'(want.forward));
                    if (msg_out_ch.status_out !== want.status)
                        report_mismatch("status_out", 32'(msg_out_ch.status_out),
                                        32'(want.status));
                    if (msg_out_ch.data1_out !== want.data1)
                        report_mismatch("data1_out", 32'(msg_out_ch.data1_out),
                                        32'(want.data1));
                    if (msg_out_ch.data2_out !== want.data2)
                        report_mismatch("data2_out", 32'(msg_out_ch.data2_out),
                                        32'(want.data2));
                    if (msg_out_ch.sent_total !== want.total)
                        report_mismatch("sent_total", msg_out_ch.sent_total, want.total);
                end
            end
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0)
                rx_mode <= $urandom_range(0, 3);
            if (hold_left > 0)
                msg_out_ch.ready <= 1'b0;
            else
            begin
                case (rx_mode)
                    0: msg_out_ch.ready <= 1'b1;
                    1: msg_out_ch.ready <= 1'($urandom_range(0, 1));
                    2: msg_out_ch.ready <= (rx_cycle % 4 == 0);
                    default: msg_out_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        msg_in_ch.valid        = 1'b0;
        msg_in_ch.cmd          = 8'h00;
        msg_in_ch.first_data   = 8'h00;
        msg_in_ch.second_data  = 8'h00;
        msg_out_ch.ready       = 1'b0;
        mismatches             = 0;
        in_beats               = 0;
        gap_left               = 0;
        burst_left             = 0;
        hold_left              = 0;
        hold_done              = 1'b0;
        rx_cycle               = 0;
        rx_mode                = 0;
        sent_count             = '0;
        foreach (cc_last[i])
            cc_last[i] = EMPTY_ENTRY;
        foreach (program_last[i])
            program_last[i] = EMPTY_ENTRY;

        // Repeats, masking of the top data bit and untouched stores first.
        add_message({TYPE_CC, 4'h0}, 8'h00, 8'h00);
        add_message({TYPE_CC, 4'h0}, 8'h00, 8'h00);
        add_message({TYPE_CC, 4'h0}, 8'h00, 8'h01);
        add_message({TYPE_CC, LAST_CHAN}, 8'hFF, 8'hFF);
        add_message({TYPE_CC, LAST_CHAN}, 8'h7F, 8'h7F);
        add_message({TYPE_CC, LAST_CHAN}, 8'h7F, 8'h80);
        add_message({TYPE_CC, 4'h1}, 8'h00, 8'h00);
        add_message({TYPE_PROGRAM, 4'h0}, 8'h00, 8'h00);
        add_message({TYPE_PROGRAM, 4'h0}, 8'h80, 8'h55);
        add_message({TYPE_PROGRAM, 4'h0}, 8'h01, 8'hFF);
        add_message({TYPE_PROGRAM, LAST_CHAN}, 8'h7F, 8'h00);
        add_message({TYPE_PROGRAM, LAST_CHAN}, 8'hFF, 8'h7F);
        add_message({TYPE_PROGRAM, LAST_CHAN}, 8'h7E, 8'h00);
        add_message({TYPE_NOTE_OFF, 4'h3}, 8'h3C, 8'h40);
        add_message({TYPE_NOTE_ON, 4'h3}, 8'h3C, 8'h7F);
        add_message({TYPE_NOTE_ON, 4'h3}, 8'h3C, 8'h7F);
        add_message({TYPE_POLY_AT, 4'h5}, 8'hFF, 8'hFF);
        add_message({TYPE_CHAN_AT, 4'h6}, 8'h20, 8'h00);
        add_message({TYPE_BEND, LAST_CHAN}, 8'h00, 8'h40);
        add_message({TYPE_SYSTEM, 4'h0}, 8'h00, 8'h00);
        add_message({TYPE_SYSTEM, LAST_CHAN}, 8'hFF, 8'hFF);
        add_message(8'h00, 8'h00, 8'h00);
        add_message(8'h7F, 8'h80, 8'h80);
        add_message({TYPE_CC, 4'h0}, 8'h00, 8'h01);
        for (int n = 0; n < RANDOM_MSGS; n++)
            msg_pending.push_back(random_message());

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (msg_pending.size() != 0)
            @(posedge clk);
        while (filter_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
